FILE: hw/rtl/cec_pkg.sv
`timescale 1ns / 1ps

package cec_pkg;

    // coordinate width, signed Q16.16 at 32 bits
    localparam int CW = 32;
    // difference of two coordinates
    localparam int DW = CW + 1;
    // product of two differences
    localparam int PW = 2 * DW;
    // dot product: sum of two products
    localparam int DOTW = PW + 1;
    // denominator dp - dq
    localparam int DENW = DOTW + 1;
    // quotient magnitude never exceeds the coordinate difference
    localparam int QW = DW;
    // numerator magnitude |diff| * |dp|
    localparam int NUMW = DW + DOTW;
    // chunk width of the split numerator multiply
    localparam int MC = (DOTW + 2) / 3;
    // divider stages: abs, multiply, two adds, QW steps, sign
    localparam int DIV_LAT = QW + 5;

    localparam int IN_W = ((10 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CW + 7) / 8) * 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = 2;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE = 2'd1;
    localparam logic [1:0] CNT_TWO = 2'd2;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t     x0;
        coord_t     y0;
        coord_t     x1;
        coord_t     y1;
        logic [1:0] n;
        coord_t     sx;
        coord_t     sy;
        coord_t     ex;
        coord_t     ey;
        coord_t     nx;
        coord_t     ny;
    } item_t;

    typedef struct packed {
        coord_t     x0;
        coord_t     y0;
        coord_t     x1;
        coord_t     y1;
        logic [1:0] cnt;
    } res_t;

    typedef struct packed {
        logic kp;
        logic kq;
        logic cr;
    } cls_t;

endpackage

FILE: hw/rtl/cec_div.sv
`timescale 1ns / 1ps

module cec_div
(
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [cec_pkg::DW-1:0]   diff,
    input  logic signed [cec_pkg::DOTW-1:0] dp,
    input  logic signed [cec_pkg::DENW-1:0] den,
    output logic signed [cec_pkg::DW-1:0]   quo
);

    localparam int DW = cec_pkg::DW;
    localparam int DOTW = cec_pkg::DOTW;
    localparam int DENW = cec_pkg::DENW;
    localparam int QW = cec_pkg::QW;
    localparam int NUMW = cec_pkg::NUMW;
    localparam int MC = cec_pkg::MC;
    localparam int HW = DOTW - 2 * MC;

    logic [DW-1:0]      a_num_reg;
    logic [DOTW-1:0]    a_dp_reg;
    logic [DENW-1:0]    a_den_reg;
    logic               a_neg_reg;

    logic [DW+MC-1:0]   b_pp0_reg;
    logic [DW+MC-1:0]   b_pp1_reg;
    logic [DW+HW-1:0]   b_pp2_reg;
    logic [DENW-1:0]    b_den_reg;
    logic               b_neg_reg;

    logic [NUMW-1:0]    c_sum_reg;
    logic [DW+HW-1:0]   c_pp2_reg;
    logic [DENW-1:0]    c_den_reg;
    logic               c_neg_reg;

    logic [NUMW-1:0]    d_num_reg;
    logic [DENW-1:0]    d_den_reg;
    logic               d_neg_reg;

    logic [DENW-1:0]    rem_reg [QW];
    logic [QW-1:0]      low_reg [QW];
    logic [QW-1:0]      q_reg   [QW];
    logic [DENW-1:0]    den_reg [QW];
    logic               neg_reg [QW];

    logic [DENW-1:0]    rem_next [QW];
    logic [QW-1:0]      low_next [QW];
    logic [QW-1:0]      q_next   [QW];

    logic signed [DW-1:0] quo_reg;

    always_comb
    begin
        logic [DENW:0]   t;
        logic            ge;
        t  = {DENW'(d_num_reg[NUMW-1:QW]), d_num_reg[QW-1]};
        ge = (t >= {1'b0, d_den_reg});
        rem_next[0] = ge ? DENW'(t - {1'b0, d_den_reg}) : t[DENW-1:0];
        low_next[0] = d_num_reg[QW-1:0] << 1;
        q_next[0]   = QW'(ge);
        for (int k = 1; k < QW; k++)
        begin
            t  = {rem_reg[k-1], low_reg[k-1][QW-1]};
            ge = (t >= {1'b0, den_reg[k-1]});
            rem_next[k] = ge ? DENW'(t - {1'b0, den_reg[k-1]}) : t[DENW-1:0];
            low_next[k] = low_reg[k-1] << 1;
            q_next[k]   = {q_reg[k-1][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_num_reg <= diff[DW-1] ? DW'(-diff) : DW'(diff);
            a_dp_reg  <= dp[DOTW-1] ? DOTW'(-dp) : DOTW'(dp);
            a_den_reg <= den[DENW-1] ? DENW'(-den) : DENW'(den);
            a_neg_reg <= diff[DW-1] ^ dp[DOTW-1] ^ den[DENW-1];

            b_pp0_reg <= (DW+MC)'(a_num_reg) * (DW+MC)'(a_dp_reg[MC-1:0]);
            b_pp1_reg <= (DW+MC)'(a_num_reg) * (DW+MC)'(a_dp_reg[2*MC-1:MC]);
            b_pp2_reg <= (DW+HW)'(a_num_reg) * (DW+HW)'(a_dp_reg[DOTW-1:2*MC]);
            b_den_reg <= a_den_reg;
            b_neg_reg <= a_neg_reg;

            c_sum_reg <= NUMW'(b_pp0_reg) + (NUMW'(b_pp1_reg) << MC);
            c_pp2_reg <= b_pp2_reg;
            c_den_reg <= b_den_reg;
            c_neg_reg <= b_neg_reg;

            d_num_reg <= c_sum_reg + (NUMW'(c_pp2_reg) << (2 * MC));
            d_den_reg <= c_den_reg;
            d_neg_reg <= c_neg_reg;

            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                q_reg[k]   <= q_next[k];
            end
            den_reg[0] <= d_den_reg;
            neg_reg[0] <= d_neg_reg;
            for (int k = 1; k < QW; k++)
            begin
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end

            quo_reg <= neg_reg[QW-1] ? -$signed(q_reg[QW-1]) : $signed(q_reg[QW-1]);
        end
    end

    assign quo = quo_reg;

endmodule

FILE: hw/rtl/cec_clip.sv
`timescale 1ns / 1ps

module cec_clip
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            flip,
    input  logic            in_valid,
    input  cec_pkg::item_t  in_item,
    output logic            out_valid,
    output cec_pkg::item_t  out_item
);

    localparam int CW = cec_pkg::CW;
    localparam int DW = cec_pkg::DW;
    localparam int PW = cec_pkg::PW;
    localparam int DOTW = cec_pkg::DOTW;
    localparam int DENW = cec_pkg::DENW;
    localparam int LAT = cec_pkg::DIV_LAT;

    cec_pkg::coord_t org_x;
    cec_pkg::coord_t org_y;
    cec_pkg::coord_t oth_x;
    cec_pkg::coord_t oth_y;

    logic                   v1_reg;
    cec_pkg::item_t         it1_reg;
    logic signed [DW-1:0]   ddx_reg;
    logic signed [DW-1:0]   ddy_reg;
    logic signed [DW-1:0]   pox_reg;
    logic signed [DW-1:0]   poy_reg;
    logic signed [DW-1:0]   qox_reg;
    logic signed [DW-1:0]   qoy_reg;

    logic                   v2_reg;
    cec_pkg::item_t         it2_reg;
    logic signed [PW-1:0]   ppx_reg;
    logic signed [PW-1:0]   ppy_reg;
    logic signed [PW-1:0]   pqx_reg;
    logic signed [PW-1:0]   pqy_reg;

    logic                   v3_reg;
    cec_pkg::item_t         it3_reg;
    logic signed [DOTW-1:0] dp_reg;
    logic signed [DOTW-1:0] dq_reg;

    logic                   v4_reg;
    cec_pkg::item_t         it4_reg;
    cec_pkg::cls_t          cls4_reg;
    cec_pkg::cls_t          cls_next;
    logic signed [DW-1:0]   cdx_reg;
    logic signed [DW-1:0]   cdy_reg;
    logic signed [DOTW-1:0] cdp_reg;
    logic signed [DENW-1:0] den_reg;

    logic                   dl_v_reg   [LAT];
    cec_pkg::item_t         dl_it_reg  [LAT];
    cec_pkg::cls_t          dl_cls_reg [LAT];

    logic signed [DW-1:0]   quo_x;
    logic signed [DW-1:0]   quo_y;

    logic                   out_valid_reg;
    cec_pkg::item_t         out_item_reg;
    cec_pkg::item_t         out_item_next;

    // origin is S on the first side and E on the second
    assign org_x = flip ? in_item.ex : in_item.sx;
    assign org_y = flip ? in_item.ey : in_item.sy;
    assign oth_x = flip ? in_item.sx : in_item.ex;
    assign oth_y = flip ? in_item.sy : in_item.ey;

    always_comb
    begin
        logic np;
        logic nq;
        np = dp_reg[DOTW-1];
        nq = dq_reg[DOTW-1];
        cls_next.kp = !np;
        cls_next.kq = !nq;
        cls_next.cr = (it3_reg.n == cec_pkg::CNT_TWO) && (dp_reg != '0) && (dq_reg != '0)
                      && (np != nq);
    end

    cec_div u_div_x
    (
        .clk  (clk),
        .en   (en),
        .diff (cdx_reg),
        .dp   (cdp_reg),
        .den  (den_reg),
        .quo  (quo_x)
    );

    cec_div u_div_y
    (
        .clk  (clk),
        .en   (en),
        .diff (cdy_reg),
        .dp   (cdp_reg),
        .den  (den_reg),
        .quo  (quo_y)
    );

    // assemble the kept points, then the crossing
    always_comb
    begin
        cec_pkg::item_t it;
        cec_pkg::cls_t  c;
        cec_pkg::coord_t cx;
        cec_pkg::coord_t cy;
        it = dl_it_reg[LAT-1];
        c  = dl_cls_reg[LAT-1];
        cx = CW'(DW'(it.x0) + quo_x);
        cy = CW'(DW'(it.y0) + quo_y);
        out_item_next = it;
        unique case (it.n)
            cec_pkg::CNT_ONE:
            begin
                out_item_next.n = c.kp ? cec_pkg::CNT_ONE : cec_pkg::CNT_NONE;
            end
            cec_pkg::CNT_TWO:
            begin
                if (c.kp)
                begin
                    if (!c.kq)
                    begin
                        out_item_next.x1 = cx;
                        out_item_next.y1 = cy;
                    end
                    out_item_next.n = (c.kq || c.cr) ? cec_pkg::CNT_TWO : cec_pkg::CNT_ONE;
                end
                else if (c.kq)
                begin
                    out_item_next.x0 = it.x1;
                    out_item_next.y0 = it.y1;
                    out_item_next.x1 = cx;
                    out_item_next.y1 = cy;
                    out_item_next.n = c.cr ? cec_pkg::CNT_TWO : cec_pkg::CNT_ONE;
                end
                else
                begin
                    out_item_next.x0 = cx;
                    out_item_next.y0 = cy;
                    out_item_next.n = c.cr ? cec_pkg::CNT_ONE : cec_pkg::CNT_NONE;
                end
            end
            default:
            begin
                out_item_next.n = cec_pkg::CNT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int k = 0; k < LAT; k++)
            begin
                dl_v_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            dl_v_reg[0] <= v4_reg;
            for (int k = 1; k < LAT; k++)
            begin
                dl_v_reg[k] <= dl_v_reg[k-1];
            end
            out_valid_reg <= dl_v_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg <= in_item;
            ddx_reg <= DW'(oth_x) - DW'(org_x);
            ddy_reg <= DW'(oth_y) - DW'(org_y);
            pox_reg <= DW'(in_item.x0) - DW'(org_x);
            poy_reg <= DW'(in_item.y0) - DW'(org_y);
            qox_reg <= DW'(in_item.x1) - DW'(org_x);
            qoy_reg <= DW'(in_item.y1) - DW'(org_y);

            it2_reg <= it1_reg;
            ppx_reg <= pox_reg * ddx_reg;
            ppy_reg <= poy_reg * ddy_reg;
            pqx_reg <= qox_reg * ddx_reg;
            pqy_reg <= qoy_reg * ddy_reg;

            it3_reg <= it2_reg;
            dp_reg  <= DOTW'(ppx_reg) + DOTW'(ppy_reg);
            dq_reg  <= DOTW'(pqx_reg) + DOTW'(pqy_reg);

            it4_reg  <= it3_reg;
            cls4_reg <= cls_next;
            cdx_reg  <= DW'(it3_reg.x1) - DW'(it3_reg.x0);
            cdy_reg  <= DW'(it3_reg.y1) - DW'(it3_reg.y0);
            cdp_reg  <= dp_reg;
            den_reg  <= DENW'(dp_reg) - DENW'(dq_reg);

            dl_it_reg[0]  <= it4_reg;
            dl_cls_reg[0] <= cls4_reg;
            for (int k = 1; k < LAT; k++)
            begin
                dl_it_reg[k]  <= dl_it_reg[k-1];
                dl_cls_reg[k] <= dl_cls_reg[k-1];
            end

            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

endmodule

FILE: hw/rtl/cec_front.sv
`timescale 1ns / 1ps

module cec_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  cec_pkg::item_t  in_item,
    output logic            out_valid,
    output cec_pkg::res_t   out_res
);

    localparam int DW = cec_pkg::DW;
    localparam int PW = cec_pkg::PW;
    localparam int DOTW = cec_pkg::DOTW;

    logic                   v0_reg;
    cec_pkg::item_t         it0_reg;

    logic                   c1_valid;
    cec_pkg::item_t         c1_item;
    logic                   c2_valid;
    cec_pkg::item_t         c2_item;

    logic                   f1_v_reg;
    cec_pkg::item_t         f1_it_reg;
    logic signed [DW-1:0]   f1_d0x_reg;
    logic signed [DW-1:0]   f1_d0y_reg;
    logic signed [DW-1:0]   f1_d1x_reg;
    logic signed [DW-1:0]   f1_d1y_reg;

    logic                   f2_v_reg;
    cec_pkg::item_t         f2_it_reg;
    logic signed [PW-1:0]   f2_p0x_reg;
    logic signed [PW-1:0]   f2_p0y_reg;
    logic signed [PW-1:0]   f2_p1x_reg;
    logic signed [PW-1:0]   f2_p1y_reg;

    logic                   out_valid_reg;
    cec_pkg::res_t          out_res_reg;
    cec_pkg::res_t          out_res_next;

    cec_clip u_clip_s
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .flip      (1'b0),
        .in_valid  (v0_reg),
        .in_item   (it0_reg),
        .out_valid (c1_valid),
        .out_item  (c1_item)
    );

    cec_clip u_clip_e
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .flip      (1'b1),
        .in_valid  (c1_valid),
        .in_item   (c1_item),
        .out_valid (c2_valid),
        .out_item  (c2_item)
    );

    // keep survivors on or behind the contact plane, then compact
    always_comb
    begin
        logic signed [DOTW-1:0] s0;
        logic signed [DOTW-1:0] s1;
        logic k0;
        logic k1;
        s0 = DOTW'(f2_p0x_reg) + DOTW'(f2_p0y_reg);
        s1 = DOTW'(f2_p1x_reg) + DOTW'(f2_p1y_reg);
        k0 = (f2_it_reg.n != cec_pkg::CNT_NONE) && (s0[DOTW-1] || (s0 == '0));
        k1 = (f2_it_reg.n == cec_pkg::CNT_TWO) && (s1[DOTW-1] || (s1 == '0));
        out_res_next.x0 = k0 ? f2_it_reg.x0 : f2_it_reg.x1;
        out_res_next.y0 = k0 ? f2_it_reg.y0 : f2_it_reg.y1;
        out_res_next.x1 = f2_it_reg.x1;
        out_res_next.y1 = f2_it_reg.y1;
        if (k0 && k1)
        begin
            out_res_next.cnt = cec_pkg::CNT_TWO;
        end
        else if (k0 || k1)
        begin
            out_res_next.cnt = cec_pkg::CNT_ONE;
        end
        else
        begin
            out_res_next.cnt = cec_pkg::CNT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            f1_v_reg      <= 1'b0;
            f2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= in_valid;
            f1_v_reg      <= c2_valid;
            f2_v_reg      <= f1_v_reg;
            out_valid_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it0_reg <= in_item;

            f1_it_reg  <= c2_item;
            f1_d0x_reg <= DW'(c2_item.x0) - DW'(c2_item.sx);
            f1_d0y_reg <= DW'(c2_item.y0) - DW'(c2_item.sy);
            f1_d1x_reg <= DW'(c2_item.x1) - DW'(c2_item.sx);
            f1_d1y_reg <= DW'(c2_item.y1) - DW'(c2_item.sy);

            f2_it_reg  <= f1_it_reg;
            f2_p0x_reg <= f1_d0x_reg * DW'(f1_it_reg.nx);
            f2_p0y_reg <= f1_d0y_reg * DW'(f1_it_reg.ny);
            f2_p1x_reg <= f1_d1x_reg * DW'(f1_it_reg.nx);
            f2_p1y_reg <= f1_d1y_reg * DW'(f1_it_reg.ny);

            out_res_reg <= out_res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res = out_res_reg;

endmodule

FILE: hw/rtl/cec_back.sv
`timescale 1ns / 1ps

module cec_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cec_pkg::res_t               in_res,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cec_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam int CW = cec_pkg::CW;
    localparam int AW = cec_pkg::FIFO_AW;
    localparam int DEPTH = cec_pkg::FIFO_DEPTH;

    cec_pkg::res_t  mem_reg [DEPTH];
    logic [AW-1:0]  wr_reg;
    logic [AW-1:0]  rd_reg;
    logic [AW:0]    count_reg;
    logic [AW:0]    count_next;
    logic           idx_reg;

    cec_pkg::res_t  head;
    logic           push;
    logic           load;
    logic           emit;
    logic           pop;

    logic                   tvalid_reg;
    logic [2*CW-1:0]        tdata_reg;
    logic                   tuser_reg;
    logic                   tlast_reg;

    assign head = mem_reg[rd_reg];
    assign in_ready = (count_reg != (AW+1)'(DEPTH));
    assign push = in_valid && in_ready;
    assign load = !tvalid_reg || m_tready;
    assign emit = load && (count_reg != '0);
    assign pop = emit && ((head.cnt != cec_pkg::CNT_TWO) || idx_reg);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg     <= '0;
            rd_reg     <= '0;
            count_reg  <= '0;
            idx_reg    <= 1'b0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg  <= rd_reg + 1'b1;
                idx_reg <= 1'b0;
            end
            else if (emit)
            begin
                idx_reg <= 1'b1;
            end
            if (load)
            begin
                tvalid_reg <= (count_reg != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_res;
        end
        if (emit)
        begin
            if (head.cnt == cec_pkg::CNT_NONE)
            begin
                tdata_reg <= '0;
                tuser_reg <= 1'b0;
            end
            else if (idx_reg)
            begin
                tdata_reg <= {head.y1, head.x1};
                tuser_reg <= 1'b1;
            end
            else
            begin
                tdata_reg <= {head.y0, head.x0};
                tuser_reg <= 1'b1;
            end
            tlast_reg <= pop;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata = cec_pkg::OUT_W'(tdata_reg);
    assign m_tuser = tuser_reg;
    assign m_tlast = tlast_reg;

    a_null_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        tvalid_reg && !tuser_reg |-> tlast_reg)
        else $error("result without a point is not last");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");

    a_second_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg |-> (count_reg != '0) && (head.cnt == cec_pkg::CNT_TWO))
        else $error("second point pending without a two-point entry");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !pop |=> tvalid_reg && !tlast_reg && tuser_reg)
        else $error("first of two points marked last");

endmodule

FILE: hw/rtl/contact_edge_clipper.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata (lowest bit up)                          tuser      tlast
// s_*      in   inc_start_x/y, inc_end_x/y, ref_start_x/y,     -          -
//               ref_end_x/y, normal_x/y (32 bits each)
// m_*      out  point_x, point_y (32 bits each)                has_point  last
//
// One contact case enters per cycle while s_tready is high; it yields one or two transfers on m_*.
// The path runs through two clip stages, each with a 38-stage pipelined divider
// (split multiply, one quotient bit per stage), plus the filter and queue.
// The front pipeline advances as a whole and freezes only when its last stage
// holds a case and the four-entry queue is full; s_tready follows that.
// Reset (rst_n, asynchronous) clears all valid flags and the queue.
module contact_edge_clipper
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cec_pkg::IN_W-1:0]    s_tdata,   // inc_start_x, inc_start_y, inc_end_x,
                                                   // inc_end_y, ref_start_x, ref_start_y,
                                                   // ref_end_x, ref_end_y, normal_x, normal_y
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cec_pkg::OUT_W-1:0]   m_tdata,   // point_x, point_y
    output logic                        m_tuser,   // has_point
    output logic                        m_tlast    // last
);

    localparam int CW = cec_pkg::CW;

    logic           en;
    cec_pkg::item_t in_item;
    logic           f_valid;
    cec_pkg::res_t  f_res;
    logic           b_ready;

    // unpack the case; the incident edge starts as a two-point list
    always_comb
    begin
        in_item.x0 = s_tdata[0*CW +: CW];
        in_item.y0 = s_tdata[1*CW +: CW];
        in_item.x1 = s_tdata[2*CW +: CW];
        in_item.y1 = s_tdata[3*CW +: CW];
        in_item.sx = s_tdata[4*CW +: CW];
        in_item.sy = s_tdata[5*CW +: CW];
        in_item.ex = s_tdata[6*CW +: CW];
        in_item.ey = s_tdata[7*CW +: CW];
        in_item.nx = s_tdata[8*CW +: CW];
        in_item.ny = s_tdata[9*CW +: CW];
        in_item.n  = cec_pkg::CNT_TWO;
    end

    // advance the front unless its finished case cannot enter the queue
    assign en = !f_valid || b_ready;
    assign s_tready = en;

    cec_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid && en),
        .in_item   (in_item),
        .out_valid (f_valid),
        .out_res   (f_res)
    );

    cec_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (f_valid),
        .in_ready (b_ready),
        .in_res   (f_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
